// ===== rtl/double_floating_remainder_top_assert.svh =====
// Assertion macros for the remainder block.
`ifndef DOUBLE_FLOATING_REMAINDER_TOP_ASSERT_SVH
`define DOUBLE_FLOATING_REMAINDER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DFR_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`else
`define DFR_ASSERT_IMPL(label, clk, rst_n, prop)
`endif
`ifndef SYNTHESIS
`define DFR_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define DFR_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/dfr_pkg.sv =====
package dfr_pkg;
  localparam int SigW = 53;
  localparam int ExpW = 12;
  localparam logic [63:0] FracMask = 64'h000f_ffff_ffff_ffff;
  localparam logic [63:0] QNan = 64'h7ff8_0000_0000_0000;
  localparam logic [10:0] ExpAll = 11'h7ff;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NORM, ST_LOOP, ST_PACK, ST_OUT
  } dfr_state_t;

  typedef struct packed {
    logic load;
    logic norm_a;
    logic norm_b;
    logic step;
    logic pack;
  } dfr_ctl_t;

  typedef struct packed {
    logic a_norm;
    logic b_norm;
    logic done;
    logic packed_ok;
  } dfr_sts_t;
endpackage

// ===== rtl/dfr_datapath.sv =====
module dfr_datapath
  import dfr_pkg::*;
(
  input  logic        clk,
  input  dfr_ctl_t    ctl,
  input  logic [63:0] x,
  input  logic [63:0] y,
  output dfr_sts_t    sts,
  output logic [63:0] result
);
  localparam logic signed [ExpW:0] EaOne = (ExpW+1)'(1);
  localparam logic signed [ExpW:0] ShMax = (ExpW+1)'(63);

  // Signed exponents; subnormals go below one, loop steps subtract.
  // The partial remainder is one bit wider than a significand: after a
  // subtract it is below the divisor, so the doubled value stays below 2^54.
  logic [SigW:0] a_r, a_nxt;
  logic [SigW-1:0] b_r, b_nxt;
  logic signed [ExpW:0] ea_r, ea_nxt, eb_r, eb_nxt;
  logic sign_r, sign_nxt;
  logic [SigW+1:0] diff;
  logic [SigW-1:0] rem;
  logic signed [ExpW:0] sh;
  logic [63:0] packed_v;

  always_comb begin
    diff = {1'b0, a_r} - {2'b00, b_r};
    rem = diff[SigW+1] ? a_r[SigW-1:0] : diff[SigW-1:0];
    sh = EaOne - ea_r;
    if (ea_r >= EaOne) begin
      packed_v = {1'b0, ea_r[10:0], a_r[51:0]};
    end else if (sh > ShMax) begin
      packed_v = 64'd0;
    end else begin
      packed_v = 64'(a_r) >> sh[5:0];
    end
    sts.a_norm = a_r[SigW-1];
    sts.b_norm = b_r[SigW-1];
    sts.done = (rem == '0) || (ea_r == eb_r);
    sts.packed_ok = a_r[SigW-1] || (a_r == '0);
    a_nxt = a_r; b_nxt = b_r; ea_nxt = ea_r; eb_nxt = eb_r; sign_nxt = sign_r;
    if (ctl.load) begin
      sign_nxt = x[63];
      a_nxt = {1'b0, (x[62:52] != 0), x[51:0]};
      b_nxt = {(y[62:52] != 0), y[51:0]};
      ea_nxt = (x[62:52] != 0) ? $signed({2'b0, x[62:52]}) : EaOne;
      eb_nxt = (y[62:52] != 0) ? $signed({2'b0, y[62:52]}) : EaOne;
    end else begin
      if (ctl.norm_a) begin
        a_nxt = a_r << 1; ea_nxt = ea_r - EaOne;
      end
      if (ctl.norm_b) begin
        b_nxt = b_r << 1; eb_nxt = eb_r - EaOne;
      end
      if (ctl.step) begin
        if (sts.done) begin
          a_nxt = {1'b0, rem};
        end else begin
          a_nxt = {rem, 1'b0}; ea_nxt = ea_r - EaOne;
        end
      end
      if (ctl.pack) begin
        a_nxt = a_r << 1; ea_nxt = ea_r - EaOne;
      end
    end
  end

  assign result = (a_r == '0) ? {sign_r, 63'd0} : ({sign_r, 63'd0} | packed_v);

  always_ff @(posedge clk) begin
    a_r <= a_nxt; b_r <= b_nxt; ea_r <= ea_nxt; eb_r <= eb_nxt; sign_r <= sign_nxt;
  end
endmodule

// ===== rtl/dfr_seq.sv =====
module dfr_seq
  import dfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        special,
  input  dfr_sts_t    sts,
  input  logic        out_take,
  output dfr_ctl_t    ctl,
  output dfr_state_t  state,
  output logic        use_special
);
  dfr_state_t state_r, state_nxt;
  logic spec_r, spec_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      spec_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      spec_r <= spec_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    spec_nxt = spec_r;
    ctl = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          spec_nxt = special;
          state_nxt = special ? ST_OUT : ST_NORM;
        end
      end
      ST_NORM: begin
        ctl.norm_a = !sts.a_norm;
        ctl.norm_b = !sts.b_norm;
        if (sts.a_norm && sts.b_norm) state_nxt = ST_LOOP;
      end
      ST_LOOP: begin
        ctl.step = 1'b1;
        if (sts.done) state_nxt = ST_PACK;
      end
      ST_PACK: begin
        ctl.pack = !sts.packed_ok;
        if (sts.packed_ok) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign state = state_r;
  assign use_special = spec_r;
endmodule

// ===== rtl/double_floating_remainder_top.sv =====
// Channel | Beat contents                            | Handshake
// in_     | tdata[63:0] dividend, [127:64] divisor   | in_tvalid/in_tready
// out_    | tdata[63:0] remainder bits               | out_tvalid/out_tready
//
// One beat is processed at a time by a single shared subtract/shift unit.
// Special operands (NaN, infinity, zero divisor, |x| <= |y|) go from IDLE straight to OUT.
// Otherwise: normalize (NORM), one exponent step of the shift-subtract loop per
// cycle (LOOP), and renormalize (PACK).
// Reset is synchronous and active low; it clears only the sequencer.
// The result is held on out_tdata until out_tready takes it.
module double_floating_remainder_top
  import dfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] dividend_bits, [127:64] divisor_bits
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata   // [63:0] remainder_bits
);
`include "double_floating_remainder_top_assert.svh"

  logic [63:0] x, y, ax, ay, dp_result;
  logic y_nan, special;
  logic [63:0] spec_val_r, spec_val_nxt;
  dfr_ctl_t ctl;
  dfr_sts_t sts;
  dfr_state_t state;
  logic use_special;

  assign x = in_tdata[63:0];
  assign y = in_tdata[127:64];
  assign ax = {1'b0, x[62:0]};
  assign ay = {1'b0, y[62:0]};
  assign y_nan = (y[62:52] == ExpAll) && ((y & FracMask) != 0);

  // Cases settled without the loop, and their result.
  always_comb begin
    special = 1'b1;
    if (x[62:52] == ExpAll || y_nan || ay == 0) spec_val_nxt = QNan;
    else if (ax < ay) spec_val_nxt = x;
    else if (ax == ay) spec_val_nxt = {x[63], 63'd0};
    else begin
      special = 1'b0;
      spec_val_nxt = x;
    end
  end

  assign in_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) spec_val_r <= spec_val_nxt;
  end

  dfr_seq u_seq (
    .clk(clk), .rst_n(rst_n), .start(in_tvalid && in_tready), .special(special),
    .sts(sts), .out_take(out_tready), .ctl(ctl), .state(state),
    .use_special(use_special)
  );

  dfr_datapath u_dp (
    .clk(clk), .ctl(ctl), .x(x), .y(y), .sts(sts), .result(dp_result)
  );

  assign out_tvalid = (state == ST_OUT);
  assign out_tdata = use_special ? spec_val_r : dp_result;

  `DFR_ASSERT_NEVER(a_no_overlap, clk, rst_n, in_tready && out_tvalid)
  `DFR_ASSERT_IMPL(a_out_after_take, clk, rst_n,
                   (out_tvalid && out_tready) |=> in_tready)
  `DFR_ASSERT_IMPL(a_loop_in_norm, clk, rst_n,
                   (state == ST_LOOP) |-> (sts.a_norm || ctl.step))
endmodule
